[hw/rtl/multi_pattern_censor_filter_core_assert.svh]
// Assertion macros used by the censor filter checker.
`ifndef MULTI_PATTERN_CENSOR_FILTER_CORE_ASSERT_SVH
`define MULTI_PATTERN_CENSOR_FILTER_CORE_ASSERT_SVH

// Antecedent in one cycle implies consequent in the next, ignored during reset.
`define MPCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Same, but also checked while reset is asserted.
`define MPCF_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/mpcf_pkg.sv]
// Constants, types and helpers for the multi-pattern censor filter.
`default_nettype none
package mpcf_pkg;
    localparam int NODES       = 4096;
    localparam int NODE_W      = $clog2(NODES);
    localparam int QCNT_W      = $clog2(NODES + 1);
    localparam int ALPHABET    = 26;
    localparam int LETTER_W    = 5;
    localparam int GOTO_DEPTH  = NODES * ALPHABET;
    localparam int GOTO_AW     = $clog2(GOTO_DEPTH);
    localparam int STACK_DEPTH = 65536;
    localparam int STK_W       = $clog2(STACK_DEPTH + 1);
    localparam int LEN_W       = 12;
    localparam int LEN_MAX     = 4095;
    localparam int IDX_W       = $clog2(ALPHABET);

    // Operation codes.
    localparam logic [2:0] OP_PATTERN = 3'd0;
    localparam logic [2:0] OP_BUILD   = 3'd1;
    localparam logic [2:0] OP_TEXT    = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRIE_FULL = 2'd1;
    localparam logic [1:0] ST_STK_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD_POS   = 2'd3;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE,
        S_P_RD, S_P_WB,
        S_T_RD, S_T_EN, S_T_POP, S_T_NS,
        S_R_RD, S_R_WB,
        S_B_RRD, S_B_RCK, S_B_POP, S_B_NOW, S_B_FAIL, S_B_G1, S_B_G2, S_B_G3,
        S_DONE
    } t_state;

    // Flat goto table address of a node row and letter.
    function automatic logic [GOTO_AW-1:0] goto_addr(input logic [NODE_W-1:0] node,
                                                      input logic [LETTER_W-1:0] ltr);
        goto_addr = GOTO_AW'(node) * GOTO_AW'(ALPHABET) + GOTO_AW'(ltr);
    endfunction
endpackage
`default_nettype wire

[hw/rtl/multi_pattern_censor_filter_core.sv]
// Aho-Corasick censor filter core with trie, links and node/letter stack memories.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  request | in        | i_valid / o_ready  | i_op, i_letter, i_last, i_position
//  result  | out       | o_valid / i_ready  | o_status, o_kept_length, o_removed,
//          |           |                    | o_letter_out
//
// One request at a time. A pattern letter reads its goto entry, then writes back. A text
// letter waits on the dependent goto, end length and node stack reads. Read kept reads the
// letter stack. Build links scans the root row, then each queued node's row, bound by the
// goto read port. After reset a clearing pass of NODES*ALPHABET (106496) entries zeroes the
// tables; no request is taken until it ends. A finished result waits in the output register
// while the next request is taken; a stalled output only holds the sequencer at its end.
`default_nettype none
module multi_pattern_censor_filter_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [2:0]                    i_op,
    input  wire logic [mpcf_pkg::LETTER_W-1:0] i_letter,
    input  wire logic                          i_last,
    input  wire logic [mpcf_pkg::STK_W-1:0]    i_position,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_status,
    output logic [mpcf_pkg::STK_W-1:0]         o_kept_length,
    output logic [mpcf_pkg::LEN_W-1:0]         o_removed,
    output logic [mpcf_pkg::LETTER_W-1:0]      o_letter_out
);
    import mpcf_pkg::*;

    // Memories.
    logic [NODE_W-1:0]   goto_mem [0:GOTO_DEPTH-1];
    logic [NODE_W-1:0]   fail_mem [0:NODES-1];
    logic [LEN_W-1:0]    end_mem  [0:NODES-1];
    logic [NODE_W-1:0]   bfs_mem  [0:NODES-1];
    logic [NODE_W-1:0]   ns_mem   [0:STACK_DEPTH];
    logic [LETTER_W-1:0] ls_mem   [0:STACK_DEPTH];

    // Memory ports.
    logic [GOTO_AW-1:0]  goto_ra, goto_wa;
    logic                goto_we;
    logic [NODE_W-1:0]   goto_wd, r_goto_q;
    logic [NODE_W-1:0]   fail_ra, fail_wa, fail_wd, r_fail_q;
    logic                fail_we;
    logic [NODE_W-1:0]   end_ra, end_wa;
    logic [LEN_W-1:0]    end_wd, r_end_q;
    logic                end_we;
    logic [NODE_W-1:0]   bfs_ra, bfs_wa, bfs_wd, r_bfs_q;
    logic                bfs_we;
    logic [STK_W-1:0]    ns_ra, stk_wa;
    logic [NODE_W-1:0]   ns_wd, r_ns_q;
    logic                ns_we, ls_we;
    logic [STK_W-1:0]    ls_ra;
    logic [LETTER_W-1:0] ls_wd, r_ls_q;

    // Control and datapath registers.
    t_state              r_state, n_state;
    logic [GOTO_AW-1:0]  r_clr, n_clr;
    logic [LETTER_W-1:0] r_letter, n_letter;
    logic                r_last, n_last;
    logic [STK_W-1:0]    r_pos, n_pos;
    logic [NODE_W-1:0]   r_ncnt, n_ncnt, r_ins, n_ins, r_scan, n_scan, r_nxt, n_nxt;
    logic [NODE_W-1:0]   r_now, n_now, r_f, n_f, r_c, n_c;
    logic [LEN_W-1:0]    r_plen, n_plen, r_removed, n_removed;
    logic [STK_W-1:0]    r_top, n_top;
    logic [QCNT_W-1:0]   r_head, n_head, r_tail, n_tail;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [1:0]          r_status, n_status;
    logic [LETTER_W-1:0] r_lout, n_lout;
    logic                r_ov, n_ov;
    logic [1:0]          r_o_status, n_o_status;
    logic [STK_W-1:0]    r_o_kept, n_o_kept;
    logic [LEN_W-1:0]    r_o_removed, n_o_removed;
    logic [LETTER_W-1:0] r_o_lout, n_o_lout;

    logic                accept, out_free, letter_ok, pos_ok, stk_room;
    logic [NODE_W:0]     ncnt_inc;
    logic [LEN_W-1:0]    plen_inc, rem;
    logic [NODE_W-1:0]   new_node;
    logic                trie_full;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign out_free  = !r_ov || i_ready;
    assign letter_ok = i_letter < LETTER_W'(ALPHABET);
    assign pos_ok    = (i_position != '0) && (i_position <= r_top);
    assign stk_room  = r_top < STK_W'(STACK_DEPTH);
    assign ncnt_inc  = {1'b0, r_ncnt} + (NODE_W+1)'(1);
    assign trie_full = ncnt_inc >= (NODE_W+1)'(NODES);
    assign new_node  = ncnt_inc[NODE_W-1:0];
    assign plen_inc  = (r_plen < LEN_W'(LEN_MAX)) ? r_plen + LEN_W'(1) : r_plen;
    assign rem       = (STK_W'(r_end_q) < r_top) ? r_end_q : r_top[LEN_W-1:0];

    // Memory write and read ports.
    always_ff @(posedge i_clk) begin
        if (goto_we) begin
            goto_mem[goto_wa] <= goto_wd;
        end
        r_goto_q <= goto_mem[goto_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fail_we) begin
            fail_mem[fail_wa] <= fail_wd;
        end
        r_fail_q <= fail_mem[fail_ra];
    end

    always_ff @(posedge i_clk) begin
        if (end_we) begin
            end_mem[end_wa] <= end_wd;
        end
        r_end_q <= end_mem[end_ra];
    end

    always_ff @(posedge i_clk) begin
        if (bfs_we) begin
            bfs_mem[bfs_wa] <= bfs_wd;
        end
        r_bfs_q <= bfs_mem[bfs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ns_we) begin
            ns_mem[stk_wa] <= ns_wd;
        end
        r_ns_q <= ns_mem[ns_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ls_we) begin
            ls_mem[stk_wa] <= ls_wd;
        end
        r_ls_q <= ls_mem[ls_ra];
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == GOTO_AW'(GOTO_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_PATTERN: n_state = letter_ok ? S_P_RD : S_DONE;
                        OP_BUILD:   n_state = S_B_RRD;
                        OP_TEXT:    n_state = (letter_ok && stk_room) ? S_T_RD : S_DONE;
                        OP_READ:    n_state = pos_ok ? S_R_RD : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_P_RD:   n_state = S_P_WB;
            S_P_WB:   n_state = S_DONE;
            S_T_RD:   n_state = S_T_EN;
            S_T_EN:   n_state = S_T_POP;
            S_T_POP:  n_state = (r_end_q != '0) ? S_T_NS : S_DONE;
            S_T_NS:   n_state = S_DONE;
            S_R_RD:   n_state = S_R_WB;
            S_R_WB:   n_state = S_DONE;
            S_B_RRD:  n_state = S_B_RCK;
            S_B_RCK:  n_state = (r_idx == IDX_W'(ALPHABET - 1)) ? S_B_POP : S_B_RRD;
            S_B_POP:  n_state = (r_head < r_tail) ? S_B_NOW : S_DONE;
            S_B_NOW:  n_state = S_B_FAIL;
            S_B_FAIL: n_state = S_B_G1;
            S_B_G1:   n_state = S_B_G2;
            S_B_G2:   n_state = S_B_G3;
            S_B_G3:   n_state = (r_idx == IDX_W'(ALPHABET - 1)) ? S_B_POP : S_B_G1;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath, memory controls and outputs.
    always_comb begin
        n_clr = r_clr;  n_letter = r_letter;  n_last = r_last;
        n_pos = r_pos;  n_ncnt = r_ncnt;  n_ins = r_ins;  n_scan = r_scan;
        n_nxt = r_nxt;  n_now = r_now;  n_f = r_f;  n_c = r_c;  n_plen = r_plen;
        n_removed = r_removed;  n_top = r_top;  n_head = r_head;  n_tail = r_tail;
        n_idx = r_idx;  n_status = r_status;  n_lout = r_lout;
        n_ov = r_ov && !i_ready;
        n_o_status = r_o_status;  n_o_kept = r_o_kept;
        n_o_removed = r_o_removed;  n_o_lout = r_o_lout;
        goto_ra = '0;  goto_wa = '0;  goto_we = 1'b0;  goto_wd = '0;
        fail_ra = '0;  fail_wa = '0;  fail_we = 1'b0;  fail_wd = '0;
        end_ra = '0;   end_wa = '0;   end_we = 1'b0;   end_wd = '0;
        bfs_ra = '0;   bfs_wa = '0;   bfs_we = 1'b0;   bfs_wd = '0;
        ns_ra = '0;    stk_wa = '0;   ns_we = 1'b0;    ns_wd = '0;
        ls_ra = '0;    ls_we = 1'b0;  ls_wd = '0;
        o_ready = (r_state == S_IDLE);

        case (r_state)
            // Zero the tables and the root entry of the node stack.
            S_CLR: begin
                goto_we = 1'b1;
                goto_wa = r_clr;
                if (r_clr < GOTO_AW'(NODES)) begin
                    fail_we = 1'b1;
                    fail_wa = r_clr[NODE_W-1:0];
                    end_we  = 1'b1;
                    end_wa  = r_clr[NODE_W-1:0];
                end
                if (r_clr == '0) begin
                    ns_we = 1'b1;
                end
                n_clr = r_clr + GOTO_AW'(1);
            end
            // Take the request and settle ops that need no memory access.
            S_IDLE: begin
                if (accept) begin
                    n_letter = i_letter;  n_last = i_last;
                    n_pos = i_position;
                    n_status = ST_OK;  n_removed = '0;  n_lout = '0;
                    n_head = '0;  n_tail = '0;  n_idx = '0;
                    if (i_op == OP_TEXT && letter_ok && !stk_room) begin
                        n_status = ST_STK_FULL;
                    end
                    if (i_op == OP_READ && !pos_ok) begin
                        n_status = ST_BAD_POS;
                    end
                    if (i_op == OP_CLEAR) begin
                        n_top  = '0;
                        n_scan = '0;
                    end
                end
            end
            S_P_RD: begin
                goto_ra = goto_addr(r_ins, r_letter);
            end
            // Follow or create the child, then mark a pattern end.
            S_P_WB: begin
                if (r_goto_q == '0 && trie_full) begin
                    n_status = ST_TRIE_FULL;
                    if (r_last) begin
                        n_ins  = '0;
                        n_plen = '0;
                    end
                end else begin
                    if (r_goto_q == '0) begin
                        goto_we = 1'b1;
                        goto_wa = goto_addr(r_ins, r_letter);
                        goto_wd = new_node;
                        n_ncnt  = new_node;
                    end
                    n_ins  = (r_goto_q == '0) ? new_node : r_goto_q;
                    n_plen = plen_inc;
                    if (r_last) begin
                        end_we = 1'b1;
                        end_wa = (r_goto_q == '0) ? new_node : r_goto_q;
                        end_wd = plen_inc;
                        n_ins  = '0;
                        n_plen = '0;
                    end
                end
            end
            S_T_RD: begin
                goto_ra = goto_addr(r_scan, r_letter);
            end
            // Push node and letter, and look up the end length of the new node.
            S_T_EN: begin
                n_nxt  = r_goto_q;
                n_top  = r_top + STK_W'(1);
                stk_wa = r_top + STK_W'(1);
                ns_we  = 1'b1;
                ns_wd  = r_goto_q;
                ls_we  = 1'b1;
                ls_wd  = r_letter;
                end_ra = r_goto_q;
            end
            // Pop a matched pattern and fetch the node below it, else step to the new node.
            S_T_POP: begin
                if (r_end_q != '0) begin
                    n_removed = rem;
                    n_top     = r_top - STK_W'(rem);
                    ns_ra     = r_top - STK_W'(rem);
                end else begin
                    n_scan = r_nxt;
                end
            end
            S_T_NS: begin
                n_scan = r_ns_q;
            end
            S_R_RD: begin
                ls_ra = r_pos;
            end
            S_R_WB: begin
                n_lout = r_ls_q;
            end
            // Queue the root's children.
            S_B_RRD: begin
                goto_ra = GOTO_AW'(r_idx);
            end
            S_B_RCK: begin
                if (r_goto_q != '0 && r_tail < QCNT_W'(NODES)) begin
                    bfs_we = 1'b1;
                    bfs_wa = r_tail[NODE_W-1:0];
                    bfs_wd = r_goto_q;
                    n_tail = r_tail + QCNT_W'(1);
                end
                n_idx = (r_idx == IDX_W'(ALPHABET - 1)) ? '0 : r_idx + IDX_W'(1);
            end
            // Breadth-first walk: dequeue a node and its fail link.
            S_B_POP: begin
                if (r_head < r_tail) begin
                    bfs_ra = r_head[NODE_W-1:0];
                    n_head = r_head + QCNT_W'(1);
                end
            end
            S_B_NOW: begin
                n_now   = r_bfs_q;
                fail_ra = r_bfs_q;
            end
            S_B_FAIL: begin
                n_f   = r_fail_q;
                n_idx = '0;
            end
            S_B_G1: begin
                goto_ra = goto_addr(r_now, r_idx);
            end
            S_B_G2: begin
                n_c     = r_goto_q;
                goto_ra = goto_addr(r_f, r_idx);
            end
            // Set the child's fail link or fill the missing transition.
            S_B_G3: begin
                if (r_c != '0) begin
                    fail_we = 1'b1;
                    fail_wa = r_c;
                    fail_wd = r_goto_q;
                    if (r_tail < QCNT_W'(NODES)) begin
                        bfs_we = 1'b1;
                        bfs_wa = r_tail[NODE_W-1:0];
                        bfs_wd = r_c;
                        n_tail = r_tail + QCNT_W'(1);
                    end
                end else begin
                    goto_we = 1'b1;
                    goto_wa = goto_addr(r_now, r_idx);
                    goto_wd = r_goto_q;
                end
                n_idx = (r_idx == IDX_W'(ALPHABET - 1)) ? '0 : r_idx + IDX_W'(1);
            end
            // Hand the result to the output register.
            S_DONE: begin
                if (out_free) begin
                    n_ov        = 1'b1;
                    n_o_status  = r_status;
                    n_o_kept    = r_top;
                    n_o_removed = r_removed;
                    n_o_lout    = r_lout;
                end
            end
            default: begin
                n_ov = r_ov;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ncnt  <= '0;
            r_ins   <= '0;
            r_plen  <= '0;
            r_top   <= '0;
            r_scan  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ncnt  <= n_ncnt;
            r_ins   <= n_ins;
            r_plen  <= n_plen;
            r_top   <= n_top;
            r_scan  <= n_scan;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_letter    <= n_letter;
        r_last      <= n_last;
        r_pos       <= n_pos;
        r_nxt       <= n_nxt;
        r_now       <= n_now;
        r_f         <= n_f;
        r_c         <= n_c;
        r_removed   <= n_removed;
        r_status    <= n_status;
        r_lout      <= n_lout;
        r_o_status  <= n_o_status;
        r_o_kept    <= n_o_kept;
        r_o_removed <= n_o_removed;
        r_o_lout    <= n_o_lout;
    end

    assign o_valid       = r_ov;
    assign o_status      = r_o_status;
    assign o_kept_length = r_o_kept;
    assign o_removed     = r_o_removed;
    assign o_letter_out  = r_o_lout;
endmodule
`default_nettype wire

[hw/rtl/mpcf_checker.sv]
// Port-level checker for the censor filter core, with its bind.
`default_nettype none
`include "multi_pattern_censor_filter_core_assert.svh"
module mpcf_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_ready,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic [mpcf_pkg::STK_W-1:0]    o_kept_length,
    input wire logic [mpcf_pkg::LEN_W-1:0]    o_removed
);
    // A result is held until taken.
    `MPCF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped")
    // A held result keeps its kept length and removed count.
    `MPCF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_kept_length) && $stable(o_removed), "held result changed")
    // After a request is taken the core is busy in the next cycle.
    `MPCF_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "request taken while busy")
    // Reset leaves no result pending and the core not ready.
    `MPCF_ASSERT_NEXT_ALWAYS(a_rst_clear, i_clk, !i_rst_n, !o_valid && !o_ready, "result after reset")
endmodule

bind multi_pattern_censor_filter_core mpcf_checker u_mpcf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_kept_length (o_kept_length),
    .o_removed     (o_removed)
);
`default_nettype wire

[sim/tb_multi_pattern_censor_filter_core.sv]
// Self-checking testbench for the multi-pattern censor filter core.
`timescale 1ns / 1ps
`default_nettype none
module tb_multi_pattern_censor_filter_core;
    import mpcf_pkg::*;

    // Unused operation codes, which must leave the state alone.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    // A build that queues NODES nodes is the longest quiet stretch; allow several of those.
    localparam int STALL_LIMIT = 4 * (NODES * (3 * ALPHABET + 3) + 2 * ALPHABET + 8);

    typedef struct packed {
        logic [1:0]          status;
        logic [STK_W-1:0]    kept;
        logic [LEN_W-1:0]    removed;
        logic [LETTER_W-1:0] lout;
    } t_censor_result;

    typedef struct {
        logic [2:0]          op;
        logic [LETTER_W-1:0] ltr;
        logic                last;
        logic [STK_W-1:0]    pos;
        bit                  typed;
        t_censor_result      res;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [2:0]          i_op;
    logic [LETTER_W-1:0] i_letter;
    logic                i_last;
    logic [STK_W-1:0]    i_position;
    logic                o_valid;
    logic                i_ready;
    logic [1:0]          o_status;
    logic [STK_W-1:0]    o_kept_length;
    logic [LEN_W-1:0]    o_removed;
    logic [LETTER_W-1:0] o_letter_out;

    multi_pattern_censor_filter_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_letter      (i_letter),
        .i_last        (i_last),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_kept_length (o_kept_length),
        .o_removed     (o_removed),
        .o_letter_out  (o_letter_out)
    );

    // Shadow copy of the automaton and the text stack.
    bit [NODE_W-1:0]   trie_next [GOTO_DEPTH];
    bit [NODE_W-1:0]   fail_of   [NODES];
    bit [LEN_W-1:0]    match_len [NODES];
    int                walk_queue [NODES];
    bit [NODE_W-1:0]   kept_node [STACK_DEPTH+1];
    bit [LETTER_W-1:0] kept_ltr  [STACK_DEPTH+1];
    int                nodes_used;
    int                grow_node;
    int                grow_len;
    int                text_top;
    int                scan_at;

    t_censor_result    pending_results [$];
    int                mismatches;
    int                requests_sent;
    int                results_seen;
    int                letters_censored;
    int                trie_full_hits;
    int                stack_full_hits;
    bit                calm;
    int                hold_left;
    int                quiet_cycles;

    // Complete the goto table and the fail links breadth-first.
    function automatic void link_trie();
        int head, tail, now, f, c;
        head = 0;
        tail = 0;
        for (int i = 0; i < ALPHABET; i++) begin
            c = trie_next[i];
            if (c != 0 && tail < NODES) begin
                walk_queue[tail] = c;
                tail++;
            end
        end
        while (head < tail) begin
            now = walk_queue[head];
            head++;
            f = fail_of[now];
            for (int i = 0; i < ALPHABET; i++) begin
                c = trie_next[now*ALPHABET + i];
                if (c != 0) begin
                    fail_of[c] = trie_next[f*ALPHABET + i];
                    if (tail < NODES) begin
                        walk_queue[tail] = c;
                        tail++;
                    end
                end else begin
                    trie_next[now*ALPHABET + i] = trie_next[f*ALPHABET + i];
                end
            end
        end
    endfunction

    // Apply one request to the shadow state and return the result it must give.
    function automatic t_censor_result predict_censor(logic [2:0] op, logic [LETTER_W-1:0] ltr,
                                                      logic last, logic [STK_W-1:0] pos);
        t_censor_result r;
        int nxt, en, rm;
        bit dropped;
        r = '0;
        dropped = 0;
        case (op)
            OP_PATTERN: begin
                if (ltr < ALPHABET) begin
                    nxt = trie_next[grow_node*ALPHABET + ltr];
                    if (nxt == 0) begin
                        if (nodes_used + 1 >= NODES) begin
                            r.status = ST_TRIE_FULL;
                            dropped = 1;
                        end else begin
                            nodes_used++;
                            nxt = nodes_used;
                            trie_next[grow_node*ALPHABET + ltr] = NODE_W'(nxt);
                        end
                    end
                    if (!dropped) begin
                        grow_node = nxt;
                        if (grow_len < LEN_MAX) grow_len++;
                    end
                    if (last) begin
                        if (!dropped) match_len[grow_node] = LEN_W'(grow_len);
                        grow_node = 0;
                        grow_len = 0;
                    end
                end
            end
            OP_BUILD: link_trie();
            OP_TEXT: begin
                if (ltr < ALPHABET) begin
                    if (text_top >= STACK_DEPTH) begin
                        r.status = ST_STK_FULL;
                    end else begin
                        nxt = trie_next[scan_at*ALPHABET + ltr];
                        text_top++;
                        kept_node[text_top] = NODE_W'(nxt);
                        kept_ltr[text_top] = ltr;
                        en = match_len[nxt];
                        if (en != 0) begin
                            rm = (en < text_top) ? en : text_top;
                            text_top -= rm;
                            scan_at = kept_node[text_top];
                            r.removed = LEN_W'(rm);
                        end else begin
                            scan_at = nxt;
                        end
                    end
                end
            end
            OP_READ: begin
                if (pos >= 1 && pos <= text_top) r.lout = kept_ltr[pos];
                else r.status = ST_BAD_POS;
            end
            OP_CLEAR: begin
                text_top = 0;
                scan_at = 0;
            end
            default: ;
        endcase
        r.kept = STK_W'(text_top);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Offer one request, hold it until accepted, then maybe idle.
    task automatic send_request(logic [2:0] op, logic [LETTER_W-1:0] ltr, logic last,
                                logic [STK_W-1:0] pos, bit typed = 0,
                                t_censor_result want = '0);
        t_censor_result r;
        i_valid    <= 1'b1;
        i_op       <= op;
        i_letter   <= ltr;
        i_last     <= last;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        r = predict_censor(op, ltr, last, pos);
        if (r.status == ST_TRIE_FULL) trie_full_hits++;
        if (r.status == ST_STK_FULL) stack_full_hits++;
        letters_censored += r.removed;
        pending_results.push_back(typed ? want : r);
        requests_sent++;
        if (!calm && $urandom_range(0, 99) < 20) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stop offering requests until every result is back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: random back-pressure, with a long hold when asked.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= calm || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // Compare every result with the oldest expectation.
    always @(posedge i_clk) begin
        t_censor_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("MISMATCH result with no request waiting at %0t", $realtime);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_kept_length !== want.kept)
                    report_mismatch("kept_length", o_kept_length, want.kept);
                if (o_removed !== want.removed)
                    report_mismatch("removed", o_removed, want.removed);
                if (o_letter_out !== want.lout)
                    report_mismatch("letter_out", o_letter_out, want.lout);
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("multi_pattern_censor_filter_core verification failed");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        t_stim_row rows [$];
        t_stim_row row;
        int p_len;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_op         = OP_PATTERN;
        i_letter     = '0;
        i_last       = 1'b0;
        i_position   = '0;
        mismatches   = 0;
        requests_sent = 0;
        results_seen = 0;
        letters_censored = 0;
        trie_full_hits = 0;
        stack_full_hits = 0;
        calm         = 1'b0;
        hold_left    = 0;
        quiet_cycles = 0;
        nodes_used   = 0;
        grow_node    = 0;
        grow_len     = 0;
        text_top     = 0;
        scan_at      = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows; typed results are the obvious ones on an empty trie.
        rows = '{
            '{OP_READ,    5'd0,  1'b0, 17'd0,      1, '{ST_BAD_POS, 17'd0, 12'd0, 5'd0}},
            '{OP_TEXT,    5'd0,  1'b0, 17'd0,      1, '{ST_OK,      17'd1, 12'd0, 5'd0}},
            '{OP_READ,    5'd0,  1'b0, 17'd1,      1, '{ST_OK,      17'd1, 12'd0, 5'd0}},
            '{OP_READ,    5'd0,  1'b0, 17'h1FFFF,  1, '{ST_BAD_POS, 17'd1, 12'd0, 5'd0}},
            '{OP_PATTERN, 5'd31, 1'b1, 17'd0,      1, '{ST_OK,      17'd1, 12'd0, 5'd0}},
            '{OP_SPARE_5, 5'd0,  1'b0, 17'd0,      1, '{ST_OK,      17'd1, 12'd0, 5'd0}},
            '{OP_SPARE_7, 5'd31, 1'b1, 17'h1FFFF,  1, '{ST_OK,      17'd1, 12'd0, 5'd0}},
            '{OP_TEXT,    5'd26, 1'b0, 17'd0,      1, '{ST_OK,      17'd1, 12'd0, 5'd0}},
            '{OP_CLEAR,   5'd0,  1'b0, 17'd0,      1, '{ST_OK,      17'd0, 12'd0, 5'd0}},
            '{OP_PATTERN, 5'd0,  1'b0, 17'd0,      0, '0},
            '{OP_PATTERN, 5'd1,  1'b1, 17'd0,      0, '0},
            '{OP_PATTERN, 5'd1,  1'b0, 17'd0,      0, '0},
            '{OP_PATTERN, 5'd2,  1'b1, 17'd0,      0, '0},
            '{OP_PATTERN, 5'd25, 1'b1, 17'd0,      0, '0},
            '{OP_BUILD,   5'd0,  1'b0, 17'd0,      0, '0},
            '{OP_TEXT,    5'd0,  1'b0, 17'd0,      0, '0},
            '{OP_TEXT,    5'd1,  1'b0, 17'd0,      0, '0},
            '{OP_TEXT,    5'd1,  1'b0, 17'd0,      0, '0},
            '{OP_TEXT,    5'd2,  1'b0, 17'd0,      0, '0},
            '{OP_TEXT,    5'd25, 1'b0, 17'd0,      0, '0},
            '{OP_TEXT,    5'd3,  1'b0, 17'd0,      0, '0},
            '{OP_READ,    5'd0,  1'b0, 17'd1,      0, '0},
            '{OP_CLEAR,   5'd0,  1'b0, 17'd0,      0, '0}
        };
        foreach (rows[i]) begin
            row = rows[i];
            send_request(row.op, row.ltr, row.last, row.pos, row.typed, row.res);
        end
        drain_results();
        send_request(OP_CLEAR, 5'd0, 1'b0, 17'd0);

        // Hold the result side off while requests keep coming.
        hold_left = 300;
        repeat (40) send_request(OP_TEXT, 5'($urandom_range(0, 4)), 1'b0, 17'd0);

        // Random rounds: a few short patterns, a build, then text over a small alphabet.
        for (int round = 0; round < 16; round++) begin
            calm = (round == 8);
            repeat ($urandom_range(1, 2)) begin
                p_len = $urandom_range(1, 4);
                for (int k = 0; k < p_len; k++)
                    send_request(OP_PATTERN, 5'($urandom_range(0, 3)), k == p_len - 1,
                                 17'($urandom));
            end
            send_request(OP_BUILD, 5'($urandom), 1'($urandom), 17'($urandom));
            repeat (95) begin
                case ($urandom_range(0, 19))
                    0:       send_request(OP_TEXT, 5'($urandom_range(26, 31)), 1'($urandom),
                                          17'($urandom));
                    1:       send_request(3'($urandom_range(5, 7)), 5'($urandom),
                                          1'($urandom), 17'($urandom));
                    2:       send_request(OP_READ, 5'($urandom), 1'($urandom), 17'($urandom));
                    3, 4:    send_request(OP_READ, 5'($urandom), 1'($urandom),
                                          17'($urandom_range(0, text_top + 1)));
                    5:       send_request(OP_PATTERN, 5'($urandom_range(26, 31)), 1'b1, 17'd0);
                    default: send_request(OP_TEXT, 5'($urandom_range(0, 4)), 1'($urandom),
                                          17'($urandom));
                endcase
            end
            if (round % 4 == 3) drain_results();
            send_request(OP_CLEAR, 5'($urandom), 1'($urandom), 17'($urandom));
        end
        calm = 1'b0;

        // A short tail of text over the whole alphabet.
        repeat (20) send_request(OP_TEXT, 5'($urandom_range(0, 25)), 1'b0, 17'd0);
        send_request(OP_READ, 5'd0, 1'b0, 17'd1);

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("covered %0d requests, %0d results, %0d letters censored",
                 requests_sent, results_seen, letters_censored);
        $display("trie full seen %0d times, stack full seen %0d times",
                 trie_full_hits, stack_full_hits);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("multi_pattern_censor_filter_core verification clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_results.size());
            $display("multi_pattern_censor_filter_core verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
